### rtl/core/egc_pkg.sv
package egc_pkg;

  localparam int unsigned VtxW = 5;
  localparam int unsigned CntW = 6;
  localparam int unsigned VidW = 6;

  localparam logic [CntW-1:0] VcountReset = 6'd32;
  localparam logic [CntW-1:0] OddMax      = 6'd63;
  localparam logic [CntW-1:0] EulerOdd    = 6'd2;

  typedef logic [VtxW-1:0] vtx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [VidW-1:0] vid_t;

  typedef struct packed {
    logic en;
    vid_t a;
    vid_t b;
  } adj_wr_t;

  typedef struct packed {
    logic en;
    vid_t addr;
  } adj_rd_t;

  typedef struct packed {
    logic accept;
    logic bad;
    logic last;
  } item_t;

  typedef struct packed {
    logic is_connected;
    logic is_eulerian;
    cnt_t odd_vertex_count;
    logic bad_edge_seen;
  } egc_res_t;

endpackage

### rtl/core/egc_ifs.sv
interface egc_cfg_if;
  logic              valid;
  logic              ready;
  egc_pkg::cnt_t     vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

interface egc_edge_if;
  logic              valid;
  logic              ready;
  logic              edge_valid;
  egc_pkg::vtx_t     end_a;
  egc_pkg::vtx_t     end_b;
  logic              last_item;

  modport source (output valid, edge_valid, end_a, end_b, last_item, input ready);
  modport sink (input valid, edge_valid, end_a, end_b, last_item, output ready);
endinterface

interface egc_res_if;
  logic              valid;
  logic              ready;
  logic              is_connected;
  logic              is_eulerian;
  egc_pkg::cnt_t     odd_vertex_count;
  logic              bad_edge_seen;

  modport source (output valid, is_connected, is_eulerian, odd_vertex_count, bad_edge_seen,
                  input ready);
  modport sink (input valid, is_connected, is_eulerian, odd_vertex_count, bad_edge_seen,
                output ready);
endinterface

### rtl/core/eulerian_graph_check.sv
// Eulerian path check for an undirected multigraph.
// The edge channel carries one word per edge: edge_valid, the endpoints end_a and
// end_b, and last_item, which closes the graph. Edges load at one word per cycle.
// An endpoint at or above vertex_count or MAX_VERTICES drops the edge and sets bad_edge_seen.
// The word that has last_item set (its edge is loaded first) starts the evaluation:
// a serial pass over all MAX_VERTICES vertices counts the odd-degree ones, then a walk
// from the lowest vertex with edges reads one adjacency row per visited vertex.
// The adjacency memories have a single read port, so for each reached vertex the
// walk issues a read and then merges the returned row. The edge channel holds
// ready low during evaluation and until the result enters the output register.
// The result channel is a registered stage, so loading of the next graph resumes
// while the receiver stalls; a second result waits until the first is taken.
// The configuration channel is always ready and writes vertex_count; it must be
// written only while no graph is being evaluated.
// Reset empties the graph, drops any pending result and sets vertex_count to 32.
module eulerian_graph_check #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  egc_cfg_if.sink  cfg_i,
  egc_edge_if.sink edge_i,
  egc_res_if.source res_o
);

  egc_pkg::cnt_t           vcount_q;
  logic [MAX_VERTICES-1:0] vmask;
  logic                    in_a;
  logic                    in_b;
  egc_pkg::item_t          item;
  egc_pkg::adj_wr_t        wr;
  egc_pkg::adj_rd_t        rd;
  logic [MAX_VERTICES-1:0] row;
  logic                    clear;
  logic                    idle;
  logic                    res_vld;
  logic                    res_take;
  egc_pkg::egc_res_t       res;
  logic                    out_vld_q;
  egc_pkg::egc_res_t       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= egc_pkg::VcountReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      vcount_q <= cfg_i.vertex_count;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      vmask[k] = ({1'b0, vcount_q} > 7'(k));
    end
  end

  assign in_a = ({2'b0, edge_i.end_a} < {1'b0, vcount_q}) &&
                ({2'b0, edge_i.end_a} < 7'(MAX_VERTICES));
  assign in_b = ({2'b0, edge_i.end_b} < {1'b0, vcount_q}) &&
                ({2'b0, edge_i.end_b} < 7'(MAX_VERTICES));

  assign edge_i.ready = idle;
  assign item.accept  = edge_i.valid && edge_i.ready;
  assign item.bad     = item.accept && edge_i.edge_valid && !(in_a && in_b);
  assign item.last    = edge_i.last_item;
  assign wr.en        = item.accept && edge_i.edge_valid && in_a && in_b;
  assign wr.a         = egc_pkg::vid_t'(edge_i.end_a);
  assign wr.b         = egc_pkg::vid_t'(edge_i.end_b);

  egc_adj_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .wr_i    (wr),
    .rd_i    (rd),
    .row_o   (row)
  );

  egc_walk #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .wr_i       (wr),
    .mask_i     (vmask),
    .row_i      (row),
    .res_take_i (res_take),
    .idle_o     (idle),
    .rd_o       (rd),
    .clear_o    (clear),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  assign res_take = !out_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld && res_take) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && res_take) begin
      out_q <= res;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.is_connected     = out_q.is_connected;
  assign res_o.is_eulerian      = out_q.is_eulerian;
  assign res_o.odd_vertex_count = out_q.odd_vertex_count;
  assign res_o.bad_edge_seen    = out_q.bad_edge_seen;

endmodule

### rtl/core/egc_adj_mem.sv
module egc_adj_mem #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  egc_pkg::adj_wr_t        wr_i,
  input  egc_pkg::adj_rd_t        rd_i,
  output logic [MAX_VERTICES-1:0] row_o
);

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);

  // Each edge is written once into each memory: the forward memory holds row a with
  // bit b, the reverse memory holds row b with bit a. Their union is the symmetric row.
  logic [MAX_VERTICES-1:0] fwd_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rev_mem [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] fwd_vld_q;
  logic [MAX_VERTICES-1:0] rev_vld_q;
  logic                    fwd_hit_q;
  logic                    rev_hit_q;
  logic [MAX_VERTICES-1:0] fwd_rd_q;
  logic [MAX_VERTICES-1:0] rev_rd_q;

  logic [IdxW-1:0]         wa;
  logic [IdxW-1:0]         wb;
  logic [IdxW-1:0]         ra;
  logic [MAX_VERTICES-1:0] bit_a;
  logic [MAX_VERTICES-1:0] bit_b;

  assign wa    = wr_i.a[IdxW-1:0];
  assign wb    = wr_i.b[IdxW-1:0];
  assign ra    = rd_i.addr[IdxW-1:0];
  assign bit_a = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wa;
  assign bit_b = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wb;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (fwd_vld_q[wa]) begin
        fwd_mem[wa][wb] <= 1'b1;
      end else begin
        fwd_mem[wa] <= bit_b;
      end
      if (rev_vld_q[wb]) begin
        rev_mem[wb][wa] <= 1'b1;
      end else begin
        rev_mem[wb] <= bit_a;
      end
    end
    if (rd_i.en) begin
      fwd_rd_q <= fwd_mem[ra];
      rev_rd_q <= rev_mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= '0;
      rev_vld_q <= '0;
      fwd_hit_q <= 1'b0;
      rev_hit_q <= 1'b0;
    end else begin
      if (clear_i) begin
        fwd_vld_q <= '0;
        rev_vld_q <= '0;
      end else if (wr_i.en) begin
        fwd_vld_q[wa] <= 1'b1;
        rev_vld_q[wb] <= 1'b1;
      end
      if (rd_i.en) begin
        fwd_hit_q <= fwd_vld_q[ra];
        rev_hit_q <= rev_vld_q[ra];
      end
    end
  end

  assign row_o = (fwd_hit_q ? fwd_rd_q : '0) | (rev_hit_q ? rev_rd_q : '0);

endmodule

### rtl/core/egc_walk.sv
module egc_walk #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  egc_pkg::item_t          item_i,
  input  egc_pkg::adj_wr_t        wr_i,
  input  logic [MAX_VERTICES-1:0] mask_i,
  input  logic [MAX_VERTICES-1:0] row_i,
  input  logic                    res_take_i,
  output logic                    idle_o,
  output egc_pkg::adj_rd_t        rd_o,
  output logic                    clear_o,
  output logic                    res_vld_o,
  output egc_pkg::egc_res_t       res_o
);

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);

  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StCount  = 3'd1;
  localparam logic [2:0] StIssue  = 3'd2;
  localparam logic [2:0] StUpdate = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [MAX_VERTICES-1:0] parity_q, parity_d;
  logic [MAX_VERTICES-1:0] has_q, has_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] expanded_q, expanded_d;
  logic                    bad_q, bad_d;
  egc_pkg::cnt_t           odd_q, odd_d;
  logic [IdxW-1:0]         idx_q, idx_d;

  logic [MAX_VERTICES-1:0] bit_a;
  logic [MAX_VERTICES-1:0] bit_b;
  logic [MAX_VERTICES-1:0] live;
  logic [MAX_VERTICES-1:0] pending;
  logic [MAX_VERTICES-1:0] pick;
  logic [IdxW-1:0]         pick_idx;
  logic                    par_bit;
  logic                    conn;

  assign bit_a   = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wr_i.a[IdxW-1:0];
  assign bit_b   = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wr_i.b[IdxW-1:0];
  assign live    = has_q & mask_i;
  assign pending = visited_q & ~expanded_q;
  assign pick    = pending & (~pending + {{(MAX_VERTICES-1){1'b0}}, 1'b1});
  assign par_bit = parity_q[idx_q] & mask_i[idx_q];
  assign conn    = (live != '0) && ((live & ~visited_q) == '0);

  always_comb begin
    pick_idx = '0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (pick[k]) begin
        pick_idx = IdxW'(k);
      end
    end
  end

  assign idle_o                 = (state_q == StLoad);
  assign res_o.is_connected     = conn;
  assign res_o.is_eulerian      = conn && (odd_q == '0 || odd_q == egc_pkg::EulerOdd);
  assign res_o.odd_vertex_count = odd_q;
  assign res_o.bad_edge_seen    = bad_q;

  always_comb begin
    state_d    = state_q;
    parity_d   = parity_q;
    has_d      = has_q;
    visited_d  = visited_q;
    expanded_d = expanded_q;
    bad_d      = bad_q;
    odd_d      = odd_q;
    idx_d      = idx_q;
    rd_o.en    = 1'b0;
    rd_o.addr  = '0;
    clear_o    = 1'b0;
    res_vld_o  = 1'b0;
    case (state_q)
      StLoad: begin
        if (item_i.accept) begin
          if (wr_i.en) begin
            // A self-loop flips the same bit twice and leaves the parity unchanged.
            has_d    = has_q | bit_a | bit_b;
            parity_d = parity_q ^ bit_a ^ bit_b;
          end
          if (item_i.bad) begin
            bad_d = 1'b1;
          end
          if (item_i.last) begin
            idx_d   = '0;
            odd_d   = '0;
            state_d = StCount;
          end
        end
      end
      StCount: begin
        if (par_bit && odd_q != egc_pkg::OddMax) begin
          odd_d = odd_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(MAX_VERTICES - 1)) begin
          visited_d  = live & (~live + {{(MAX_VERTICES-1){1'b0}}, 1'b1});
          expanded_d = '0;
          state_d    = StIssue;
        end
      end
      StIssue: begin
        if (pending == '0) begin
          state_d = StDone;
        end else begin
          rd_o.en    = 1'b1;
          rd_o.addr  = egc_pkg::vid_t'(pick_idx);
          expanded_d = expanded_q | pick;
          state_d    = StUpdate;
        end
      end
      StUpdate: begin
        visited_d = visited_q | (row_i & mask_i);
        state_d   = StIssue;
      end
      StDone: begin
        res_vld_o = 1'b1;
        if (res_take_i) begin
          clear_o    = 1'b1;
          parity_d   = '0;
          has_d      = '0;
          visited_d  = '0;
          expanded_d = '0;
          bad_d      = 1'b0;
          state_d    = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      parity_q   <= '0;
      has_q      <= '0;
      visited_q  <= '0;
      expanded_q <= '0;
      bad_q      <= 1'b0;
      odd_q      <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      parity_q   <= parity_d;
      has_q      <= has_d;
      visited_q  <= visited_d;
      expanded_q <= expanded_d;
      bad_q      <= bad_d;
      odd_q      <= odd_d;
      idx_q      <= idx_d;
    end
  end

  a_expanded_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expanded_q & ~visited_q) == '0)
    else $error("expanded vertex was never marked visited");

  a_update_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpdate |-> $past(state_q) == StIssue && $past(rd_o.en))
    else $error("row update without a preceding read");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> visited_q == '0 && expanded_q == '0)
    else $error("walk state not cleared while loading");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> state_q == StLoad)
    else $error("adjacency write outside of loading");

endmodule

### test/testbench.sv
module testbench;

  localparam int unsigned Vertices = 32;
  localparam int unsigned Settle = 3 * Vertices + 4;
  localparam int unsigned RandomWords = 1600;

  logic clk_i;
  logic rst_ni;

  egc_cfg_if  cfg_if ();
  egc_edge_if edge_if ();
  egc_res_if  res_if ();

  eulerian_graph_check u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .edge_i (edge_if),
    .res_o  (res_if)
  );

  logic [Vertices-1:0] graph_rows [Vertices];
  logic [Vertices-1:0] odd_parity;
  logic [Vertices-1:0] touched;
  logic                bad_seen;
  egc_pkg::cnt_t       vcount;

  egc_pkg::egc_res_t pending_verdicts [$];
  int unsigned       words_sent;
  bit                steady;
  bit                sink_steady;
  bit                failed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void clear_graph();
    for (int k = 0; k < Vertices; k++) graph_rows[k] = '0;
    odd_parity = '0;
    touched = '0;
    bad_seen = 1'b0;
  endfunction

  function automatic int unsigned live_vertices();
    return (vcount > Vertices) ? Vertices : vcount;
  endfunction

  function automatic void absorb_edge(logic ev, egc_pkg::vtx_t a, egc_pkg::vtx_t b);
    int unsigned n;
    n = live_vertices();
    if (ev) begin
      if (a >= n || b >= n) begin
        bad_seen = 1'b1;
      end else begin
        graph_rows[a][b] = 1'b1;
        graph_rows[b][a] = 1'b1;
        touched[a] = 1'b1;
        touched[b] = 1'b1;
        if (a != b) begin
          odd_parity[a] = ~odd_parity[a];
          odd_parity[b] = ~odd_parity[b];
        end
      end
    end
  endfunction

  // Reachability is grown to a fixed point; it matches what the walk in the design marks.
  function automatic egc_pkg::egc_res_t judge_graph();
    egc_pkg::egc_res_t   verdict;
    logic [Vertices-1:0] span_mask;
    logic [Vertices-1:0] live;
    logic [Vertices-1:0] reached;
    logic [Vertices-1:0] prior;
    int unsigned         n;
    int unsigned         odd;
    n = live_vertices();
    span_mask = (n >= Vertices) ? '1 : ((Vertices'(1) << n) - 1'b1);
    live = touched & span_mask;
    reached = live & (~live + 1'b1);
    do begin
      prior = reached;
      for (int k = 0; k < Vertices; k++) begin
        if (reached[k]) reached |= graph_rows[k] & span_mask;
      end
    end while (reached != prior);
    odd = $countones(odd_parity & span_mask);
    if (odd > egc_pkg::OddMax) odd = egc_pkg::OddMax;
    verdict.is_connected = (live != '0) && ((live & ~reached) == '0);
    verdict.odd_vertex_count = egc_pkg::cnt_t'(odd);
    verdict.is_eulerian = verdict.is_connected && (odd == 0 || odd == egc_pkg::EulerOdd);
    verdict.bad_edge_seen = bad_seen;
    clear_graph();
    return verdict;
  endfunction

  function automatic int unsigned draw_gap(bit no_wait);
    return no_wait ? 0 : $urandom_range(13, 0);
  endfunction

  task automatic send_word(logic ev, int unsigned a, int unsigned b, logic last);
    int unsigned gap;
    gap = draw_gap(steady);
    if (gap != 0) begin
      edge_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_if.valid      <= 1'b1;
    edge_if.edge_valid <= ev;
    edge_if.end_a      <= egc_pkg::vtx_t'(a);
    edge_if.end_b      <= egc_pkg::vtx_t'(b);
    edge_if.last_item  <= last;
    do @(posedge clk_i); while (!edge_if.ready);
    absorb_edge(ev, egc_pkg::vtx_t'(a), egc_pkg::vtx_t'(b));
    if (ev || last) words_sent++;
    if (last) pending_verdicts.insert(pending_verdicts.size(), judge_graph());
  endtask

  task automatic drain_and_settle();
    edge_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(egc_pkg::cnt_t value);
    drain_and_settle();
    cfg_if.valid        <= 1'b1;
    cfg_if.vertex_count <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    vcount = value;
  endtask

  task automatic test_small_graphs();
    steady = 1'b0;
    send_word(1'b0, 0, 0, 1'b1);
    send_word(1'b1, 5, 5, 1'b1);
    send_word(1'b1, 0, 1, 1'b0);
    send_word(1'b1, 1, 2, 1'b0);
    send_word(1'b1, 2, 0, 1'b1);
    send_word(1'b1, 0, 31, 1'b0);
    send_word(1'b0, 31, 31, 1'b0);
    send_word(1'b1, 31, 30, 1'b1);
    send_word(1'b1, 0, 1, 1'b0);
    send_word(1'b1, 2, 3, 1'b0);
    send_word(1'b0, 0, 0, 1'b1);
    send_word(1'b1, 7, 8, 1'b0);
    send_word(1'b1, 7, 9, 1'b0);
    send_word(1'b1, 7, 10, 1'b0);
    send_word(1'b1, 7, 11, 1'b1);
    send_word(1'b1, 3, 4, 1'b0);
    send_word(1'b1, 4, 3, 1'b1);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(6'd1);
    send_word(1'b1, 0, 0, 1'b0);
    send_word(1'b1, 0, 1, 1'b1);
    write_vertex_count(6'd0);
    send_word(1'b1, 0, 0, 1'b1);
    write_vertex_count(6'd63);
    send_word(1'b1, 31, 30, 1'b1);
    write_vertex_count(6'd33);
    send_word(1'b1, 31, 31, 1'b1);
    write_vertex_count(6'd2);
    send_word(1'b1, 1, 0, 1'b0);
    send_word(1'b1, 2, 1, 1'b1);
  endtask

  // Vertices at or above the new count drop out of the walk and the parity count.
  task automatic test_count_change_mid_graph();
    write_vertex_count(6'd32);
    send_word(1'b1, 0, 1, 1'b0);
    send_word(1'b1, 1, 20, 1'b0);
    send_word(1'b1, 20, 21, 1'b0);
    write_vertex_count(6'd16);
    send_word(1'b1, 0, 2, 1'b1);
  endtask

  task automatic send_random_graph();
    int unsigned lim;
    int unsigned span;
    int unsigned base;
    int unsigned edges;
    int unsigned cur;
    int unsigned a;
    int unsigned b;
    int unsigned roll;
    bit          chain;
    bit          bare_last;
    lim = (live_vertices() == 0) ? Vertices : live_vertices();
    span = ($urandom_range(4, 0) == 0) ? $urandom_range(lim, 1)
                                      : $urandom_range((lim < 6) ? lim : 6, 1);
    base = $urandom_range(lim - span, 0);
    edges = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 12) : $urandom_range(8, 1);
    chain = $urandom_range(1, 0);
    bare_last = ($urandom_range(3, 0) == 0);
    cur = base + $urandom_range(span - 1, 0);
    steady = ($urandom_range(4, 0) == 0);
    for (int unsigned i = 0; i < edges; i++) begin
      if (chain) begin
        a = cur;
        b = base + $urandom_range(span - 1, 0);
        cur = b;
      end else begin
        a = base + $urandom_range(span - 1, 0);
        b = base + $urandom_range(span - 1, 0);
      end
      roll = $urandom_range(19, 0);
      if (roll == 0) a = $urandom_range(31, 0);
      if (roll == 1) b = $urandom_range(31, 0);
      if (roll == 2) send_word(1'b0, $urandom_range(31, 0), $urandom_range(31, 0), 1'b0);
      send_word(1'b1, a, b, (i == edges - 1) && !bare_last);
    end
    if (bare_last) send_word(1'b0, $urandom_range(31, 0), $urandom_range(31, 0), 1'b1);
  endtask

  task automatic test_random_graphs();
    egc_pkg::cnt_t plan [] = '{6'd32, 6'd1, 6'd8, 6'd63, 6'd2, 6'd0, 6'd20, 6'd33, 6'd32};
    int unsigned   finish_at;
    int unsigned   phase_end;
    int unsigned   phase;
    egc_pkg::cnt_t setting;
    finish_at = words_sent + RandomWords;
    phase = 0;
    while (words_sent < finish_at) begin
      setting = (phase < plan.size()) ? plan[phase]
                                      : egc_pkg::cnt_t'($urandom_range(32, 1));
      write_vertex_count(setting);
      phase_end = words_sent + 160;
      while (words_sent < phase_end && words_sent < finish_at) send_random_graph();
      phase++;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    egc_pkg::egc_res_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("result word with no graph waiting for it");
        failed = 1'b1;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("is_connected", want.is_connected, res_if.is_connected);
        check_field("is_eulerian", want.is_eulerian, res_if.is_eulerian);
        check_field("odd_vertex_count", want.odd_vertex_count, res_if.odd_vertex_count);
        check_field("bad_edge_seen", want.bad_edge_seen, res_if.bad_edge_seen);
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    sink_steady = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(7, 0) == 0) sink_steady = ~sink_steady;
      stall = draw_gap(sink_steady);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.vertex_count <= egc_pkg::VcountReset;
    edge_if.valid       <= 1'b0;
    edge_if.edge_valid  <= 1'b0;
    edge_if.end_a       <= '0;
    edge_if.end_b       <= '0;
    edge_if.last_item   <= 1'b0;
    failed = 1'b0;
    words_sent = 0;
    steady = 1'b0;
    vcount = egc_pkg::VcountReset;
    clear_graph();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_graphs();
    test_vertex_count_limits();
    test_count_change_mid_graph();
    test_random_graphs();
    drain_and_settle();
    if (!failed) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/egc_pkg.sv
rtl/core/egc_ifs.sv
rtl/core/egc_adj_mem.sv
rtl/core/egc_walk.sv
rtl/core/eulerian_graph_check.sv
test/testbench.sv
